@@ src/sed_pkg.sv @@
`timescale 1ns / 1ps
// types, codes and character constants for the string escape decoder
// no dependencies

package sed_pkg;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } in_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_HEX   = 2'd1,
        ST_UNPRINT   = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] decoded_unit;
        logic        unit_valid;
        logic        end_of_string;
        status_t     status;
    } out_t;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESCAPE = 3'b010,
        MODE_HEX    = 3'b100
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  digits_left;
        logic [15:0] hex_acc;
        status_t     err;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        mode:        MODE_NORMAL,
        digits_left: 3'd0,
        hex_acc:     16'h0000,
        err:         ST_OK
    };

    localparam logic [15:0] CH_BACKSLASH = 16'h005C;
    localparam logic [15:0] CH_N         = 16'h006E;
    localparam logic [15:0] CH_R         = 16'h0072;
    localparam logic [15:0] CH_V         = 16'h0076;
    localparam logic [15:0] CH_F         = 16'h0066;
    localparam logic [15:0] CH_B         = 16'h0062;
    localparam logic [15:0] CH_T         = 16'h0074;
    localparam logic [15:0] CH_ZERO      = 16'h0030;
    localparam logic [15:0] CH_X         = 16'h0078;
    localparam logic [15:0] CH_U         = 16'h0075;
    localparam logic [15:0] CH_PRINT_LO  = 16'h0020;
    localparam logic [15:0] CH_PRINT_HI  = 16'h007E;

    localparam logic [15:0] CTL_LF  = 16'h000A;
    localparam logic [15:0] CTL_CR  = 16'h000D;
    localparam logic [15:0] CTL_VT  = 16'h000B;
    localparam logic [15:0] CTL_FF  = 16'h000C;
    localparam logic [15:0] CTL_BS  = 16'h0008;
    localparam logic [15:0] CTL_TAB = 16'h0009;
    localparam logic [15:0] CTL_NUL = 16'h0000;

    localparam logic [2:0] DIGITS_X = 3'd2;
    localparam logic [2:0] DIGITS_U = 3'd4;

    // hex digit value, bit 4 set when the unit is a valid digit
    function automatic logic [4:0] hex_nibble(input logic [15:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

@@ src/sed_parse.sv @@
`timescale 1ns / 1ps
// next parse state and result word for one code unit
// depends on sed_pkg

module sed_parse (
    input  sed_pkg::in_t          in_data,
    input  sed_pkg::parse_state_t state,
    output sed_pkg::parse_state_t state_next,
    output logic                  has_result,
    output sed_pkg::out_t         result
);

    logic [15:0]          cu;
    logic [4:0]           nib;
    logic [15:0]          acc_shift;
    logic                 emit;
    logic [15:0]          val;
    sed_pkg::parse_state_t st;
    sed_pkg::status_t     status;

    assign cu        = in_data.code_unit;
    assign nib       = sed_pkg::hex_nibble(cu);
    assign acc_shift = {state.hex_acc[11:0], nib[3:0]};

    always_comb
    begin
        st   = state;
        emit = 1'b0;
        val  = 16'h0000;
        if (state.err == sed_pkg::ST_OK)
        begin
            unique case (state.mode)
                sed_pkg::MODE_ESCAPE:
                begin
                    st.mode = sed_pkg::MODE_NORMAL;
                    unique case (cu)
                        sed_pkg::CH_N:    begin emit = 1'b1; val = sed_pkg::CTL_LF;  end
                        sed_pkg::CH_R:    begin emit = 1'b1; val = sed_pkg::CTL_CR;  end
                        sed_pkg::CH_V:    begin emit = 1'b1; val = sed_pkg::CTL_VT;  end
                        sed_pkg::CH_F:    begin emit = 1'b1; val = sed_pkg::CTL_FF;  end
                        sed_pkg::CH_B:    begin emit = 1'b1; val = sed_pkg::CTL_BS;  end
                        sed_pkg::CH_T:    begin emit = 1'b1; val = sed_pkg::CTL_TAB; end
                        sed_pkg::CH_ZERO: begin emit = 1'b1; val = sed_pkg::CTL_NUL; end
                        sed_pkg::CH_X:
                        begin
                            st.mode        = sed_pkg::MODE_HEX;
                            st.digits_left = sed_pkg::DIGITS_X;
                            st.hex_acc     = 16'h0000;
                        end
                        sed_pkg::CH_U:
                        begin
                            st.mode        = sed_pkg::MODE_HEX;
                            st.digits_left = sed_pkg::DIGITS_U;
                            st.hex_acc     = 16'h0000;
                        end
                        default:
                        begin
                            if (cu >= sed_pkg::CH_PRINT_LO && cu <= sed_pkg::CH_PRINT_HI)
                            begin
                                emit = 1'b1;
                                val  = cu;
                            end
                            else
                            begin
                                st.err = sed_pkg::ST_UNPRINT;
                            end
                        end
                    endcase
                end
                sed_pkg::MODE_HEX:
                begin
                    if (!nib[4])
                    begin
                        st.err         = sed_pkg::ST_BAD_HEX;
                        st.mode        = sed_pkg::MODE_NORMAL;
                        st.digits_left = 3'd0;
                    end
                    else
                    begin
                        st.hex_acc = acc_shift;
                        if (state.digits_left <= 3'd1)
                        begin
                            st.digits_left = 3'd0;
                            st.mode        = sed_pkg::MODE_NORMAL;
                            emit           = 1'b1;
                            val            = acc_shift;
                        end
                        else
                        begin
                            st.digits_left = state.digits_left - 3'd1;
                        end
                    end
                end
                default:
                begin
                    st.mode = sed_pkg::MODE_NORMAL;
                    if (cu == sed_pkg::CH_BACKSLASH)
                    begin
                        st.mode = sed_pkg::MODE_ESCAPE;
                    end
                    else
                    begin
                        emit = 1'b1;
                        val  = cu;
                    end
                end
            endcase
        end

        status = sed_pkg::ST_OK;
        if (in_data.last_unit)
        begin
            status = st.err;
            if (status == sed_pkg::ST_OK && st.mode != sed_pkg::MODE_NORMAL)
            begin
                status = sed_pkg::ST_TRUNCATED;
            end
            if (status != sed_pkg::ST_OK)
            begin
                emit = 1'b0;
                val  = 16'h0000;
            end
            st = sed_pkg::STATE_RESET;
        end
    end

    assign state_next           = st;
    assign has_result           = emit | in_data.last_unit;
    assign result.decoded_unit  = val;
    assign result.unit_valid    = emit;
    assign result.end_of_string = in_data.last_unit;
    assign result.status        = status;

endmodule

@@ src/sed_out_buf.sv @@
`timescale 1ns / 1ps
// result register with valid/ready handshake
// depends on sed_pkg

module sed_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load_valid,
    input  sed_pkg::out_t load_data,
    output logic          can_load,
    output logic          out_valid,
    input  logic          out_ready,
    output sed_pkg::out_t out_data
);

    logic          valid_reg;
    logic          valid_next;
    sed_pkg::out_t data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = (load_valid && can_load) || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && can_load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ src/string_escape_decoder_unit.sv @@
`timescale 1ns / 1ps
// data path: an accepted word is held in the input register, then its result in the result register
// throughput: one code unit per cycle unless the result register is stalled, set by the single parse stage between
// the input register and the result register; units that decode to nothing give no word
// reset: rst_n asynchronous active low clears both stage valids and the parse state
// top level of the string escape decoder; depends on sed_pkg, sed_parse, sed_out_buf

module string_escape_decoder_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sed_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sed_pkg::out_t out_data
);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    sed_pkg::in_t          s1_data_reg;
    sed_pkg::parse_state_t state_reg;
    sed_pkg::parse_state_t state_next;
    logic                  has_result;
    sed_pkg::out_t         result;
    logic                  can_load;
    logic                  s1_fire;
    logic                  in_fire;

    sed_parse u_parse (
        .in_data    (s1_data_reg),
        .state      (state_reg),
        .state_next (state_next),
        .has_result (has_result),
        .result     (result)
    );

    sed_out_buf u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (s1_valid_reg && has_result),
        .load_data  (result),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign s1_fire       = s1_valid_reg && (!has_result || can_load);
    assign in_ready      = !s1_valid_reg || s1_fire;
    assign in_fire       = in_valid && in_ready;
    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= sed_pkg::STATE_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= in_data;
        end
    end

endmodule

@@ src/sed_checker.sv @@
`timescale 1ns / 1ps
// port-level checks on the result channel of the escape decoder
// depends on sed_pkg; bound to string_escape_decoder_unit

module sed_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_ready,
    input sed_pkg::out_t out_data
);

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // every word carries a character or ends a string
    a_useful: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.unit_valid || out_data.end_of_string))
        else $error("empty result word");

    // status only on end of string
    a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.end_of_string |-> out_data.status == sed_pkg::ST_OK)
        else $error("status set before end of string");

    // failed string produces no character
    a_err_nochar: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != sed_pkg::ST_OK |-> !out_data.unit_valid)
        else $error("character with error status");

    // no character means zero data
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.unit_valid |-> out_data.decoded_unit == 16'h0000)
        else $error("nonzero data without character");

endmodule

bind string_escape_decoder_unit sed_checker u_sed_checker (.*);

@@ tb/sed_checker.sv @@
`timescale 1ns / 1ps
// result checker for the string escape decoder: tracks the parse state of the string,
// predicts every result word and compares it field by field; depends on sed_pkg

module sed_tb_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  sed_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  sed_pkg::out_t out_data,
    output int            mismatches,
    output int            pending,
    output int            words_checked,
    output int            strings_ended,
    output int            error_ends
);

    localparam logic [15:0] DIG_0  = 16'h0030;
    localparam logic [15:0] DIG_9  = 16'h0039;
    localparam logic [15:0] LOW_A  = 16'h0061;
    localparam logic [15:0] LOW_F  = 16'h0066;
    localparam logic [15:0] UP_A   = 16'h0041;
    localparam logic [15:0] UP_F   = 16'h0046;

    sed_pkg::mode_t   cur_mode;
    logic [2:0]       digits_due;
    logic [15:0]      hex_sum;
    sed_pkg::status_t sticky_err;

    sed_pkg::out_t decoded_q[$];

    function automatic int hex_digit_value(input logic [15:0] c);
        if (c >= DIG_0 && c <= DIG_9)
        begin
            return int'(c - DIG_0);
        end
        if (c >= LOW_A && c <= LOW_F)
        begin
            return int'(c - LOW_A) + 10;
        end
        if (c >= UP_A && c <= UP_F)
        begin
            return int'(c - UP_A) + 10;
        end
        return -1;
    endfunction

    task automatic clear_parse();
        cur_mode   = sed_pkg::MODE_NORMAL;
        digits_due = 3'd0;
        hex_sum    = 16'h0000;
        sticky_err = sed_pkg::ST_OK;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
    endtask

    task automatic decode_word(input sed_pkg::in_t w, output bit emit,
                               output sed_pkg::out_t r);
        logic [15:0]      cu;
        bit               got;
        logic [15:0]      val;
        int               nib;
        sed_pkg::status_t st;
        cu  = w.code_unit;
        got = 1'b0;
        val = 16'h0000;
        if (sticky_err == sed_pkg::ST_OK)
        begin
            case (cur_mode)
                sed_pkg::MODE_ESCAPE:
                begin
                    cur_mode = sed_pkg::MODE_NORMAL;
                    case (cu)
                        sed_pkg::CH_N:    begin got = 1'b1; val = sed_pkg::CTL_LF;  end
                        sed_pkg::CH_R:    begin got = 1'b1; val = sed_pkg::CTL_CR;  end
                        sed_pkg::CH_V:    begin got = 1'b1; val = sed_pkg::CTL_VT;  end
                        sed_pkg::CH_F:    begin got = 1'b1; val = sed_pkg::CTL_FF;  end
                        sed_pkg::CH_B:    begin got = 1'b1; val = sed_pkg::CTL_BS;  end
                        sed_pkg::CH_T:    begin got = 1'b1; val = sed_pkg::CTL_TAB; end
                        sed_pkg::CH_ZERO: begin got = 1'b1; val = sed_pkg::CTL_NUL; end
                        sed_pkg::CH_X:
                        begin
                            cur_mode   = sed_pkg::MODE_HEX;
                            digits_due = sed_pkg::DIGITS_X;
                            hex_sum    = 16'h0000;
                        end
                        sed_pkg::CH_U:
                        begin
                            cur_mode   = sed_pkg::MODE_HEX;
                            digits_due = sed_pkg::DIGITS_U;
                            hex_sum    = 16'h0000;
                        end
                        default:
                        begin
                            if (cu >= sed_pkg::CH_PRINT_LO && cu <= sed_pkg::CH_PRINT_HI)
                            begin
                                got = 1'b1;
                                val = cu;
                            end
                            else
                            begin
                                sticky_err = sed_pkg::ST_UNPRINT;
                            end
                        end
                    endcase
                end
                sed_pkg::MODE_HEX:
                begin
                    nib = hex_digit_value(cu);
                    if (nib < 0)
                    begin
                        sticky_err = sed_pkg::ST_BAD_HEX;
                        cur_mode   = sed_pkg::MODE_NORMAL;
                        digits_due = 3'd0;
                    end
                    else
                    begin
                        hex_sum = {hex_sum[11:0], 4'(nib)};
                        if (digits_due <= 3'd1)
                        begin
                            digits_due = 3'd0;
                            cur_mode   = sed_pkg::MODE_NORMAL;
                            got        = 1'b1;
                            val        = hex_sum;
                        end
                        else
                        begin
                            digits_due = digits_due - 3'd1;
                        end
                    end
                end
                default:
                begin
                    cur_mode = sed_pkg::MODE_NORMAL;
                    if (cu == sed_pkg::CH_BACKSLASH)
                    begin
                        cur_mode = sed_pkg::MODE_ESCAPE;
                    end
                    else
                    begin
                        got = 1'b1;
                        val = cu;
                    end
                end
            endcase
        end
        if (!w.last_unit)
        begin
            emit = got;
            r    = '{decoded_unit: val, unit_valid: 1'b1, end_of_string: 1'b0,
                     status: sed_pkg::ST_OK};
        end
        else
        begin
            st = sticky_err;
            if (st == sed_pkg::ST_OK && cur_mode != sed_pkg::MODE_NORMAL)
            begin
                st = sed_pkg::ST_TRUNCATED;
            end
            if (st != sed_pkg::ST_OK)
            begin
                got = 1'b0;
                val = 16'h0000;
                error_ends++;
            end
            strings_ended++;
            clear_parse();
            emit = 1'b1;
            r    = '{decoded_unit: val, unit_valid: got, end_of_string: 1'b1, status: st};
        end
    endtask

    initial
    begin
        mismatches    = 0;
        pending       = 0;
        words_checked = 0;
        strings_ended = 0;
        error_ends    = 0;
        clear_parse();
    end

    always @(posedge clk or negedge rst_n)
    begin
        sed_pkg::out_t want;
        sed_pkg::out_t word;
        bit            emit;
        if (!rst_n)
        begin
            clear_parse();
            decoded_q.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    report_mismatch("word with none expected", out_data, 0);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    words_checked++;
                    if (out_data.decoded_unit !== want.decoded_unit)
                    begin
                        report_mismatch("decoded_unit", out_data.decoded_unit, want.decoded_unit);
                    end
                    if (out_data.unit_valid !== want.unit_valid)
                    begin
                        report_mismatch("unit_valid", out_data.unit_valid, want.unit_valid);
                    end
                    if (out_data.end_of_string !== want.end_of_string)
                    begin
                        report_mismatch("end_of_string", out_data.end_of_string,
                                        want.end_of_string);
                    end
                    if (out_data.status !== want.status)
                    begin
                        report_mismatch("status", out_data.status, want.status);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                decode_word(in_data, emit, word);
                if (emit)
                begin
                    decoded_q.push_back(word);
                end
            end
            pending = decoded_q.size();
        end
    end

endmodule

@@ tb/string_escape_decoder_unit_test.sv @@
`timescale 1ns / 1ps
// testbench top for string_escape_decoder_unit: drives escaped strings with random gaps
// and back pressure, gives the verdict; depends on sed_pkg and sed_tb_checker

module string_escape_decoder_unit_test;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_UNITS = 820;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    sed_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_ready;
    sed_pkg::out_t out_data;

    int mismatches;
    int pending;
    int words_checked;
    int strings_ended;
    int error_ends;

    int unsigned cycle_count;
    int          units_sent;
    int          random_sent;
    bit          in_burst;
    bit          out_burst;
    bit          out_taken;
    int          out_wait;

    string_escape_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    sed_tb_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .words_checked (words_checked),
        .strings_ended (strings_ended),
        .error_ends    (error_ends)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: after each taken word, hold ready low for a drawn number of cycles
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            out_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (out_taken)
        begin
            out_taken = 1'b0;
            out_wait  = out_burst ? 0 : $urandom_range(0, 15);
        end
        if (out_wait != 0)
        begin
            out_ready <= 1'b0;
            out_wait--;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_unit(input logic [15:0] c, input logic fin);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{code_unit: c, last_unit: fin};
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
        units_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [15:0] digit_unit(input int v);
        if (v < 10)
        begin
            return 16'h0030 + 16'(v);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            return 16'h0041 + 16'(v - 10);
        end
        return 16'h0061 + 16'(v - 10);
    endfunction

    function automatic logic [15:0] wide_unit();
        return {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
    endfunction

    function automatic logic [15:0] non_hex_unit();
        case ($urandom_range(0, 7))
            0: return 16'h002F;
            1: return 16'h003A;
            2: return 16'h0040;
            3: return 16'h0047;
            4: return 16'h0060;
            5: return 16'h0067;
            6: return 16'($urandom_range(0, 31));
            default: return wide_unit();
        endcase
    endfunction

    function automatic logic [15:0] simple_escape();
        case ($urandom_range(0, 6))
            0: return sed_pkg::CH_N;
            1: return sed_pkg::CH_R;
            2: return sed_pkg::CH_V;
            3: return sed_pkg::CH_F;
            4: return sed_pkg::CH_B;
            5: return sed_pkg::CH_T;
            default: return sed_pkg::CH_ZERO;
        endcase
    endfunction

    task automatic send_random_string();
        logic [15:0] units[$];
        int          segs;
        int          pick;
        int          ndig;
        int          cut;
        segs = $urandom_range(1, 6);
        repeat (segs)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    units.push_back(16'($urandom_range(32, 126)));
                end
                else
                begin
                    units.push_back(16'($urandom_range(0, 65535)));
                end
            end
            else if (pick < 50)
            begin
                units.push_back(sed_pkg::CH_BACKSLASH);
                units.push_back(simple_escape());
            end
            else if (pick < 60)
            begin
                units.push_back(sed_pkg::CH_BACKSLASH);
                units.push_back(16'($urandom_range(32, 126)));
            end
            else if (pick < 84)
            begin
                ndig = (pick < 72) ? 2 : 4;
                units.push_back(sed_pkg::CH_BACKSLASH);
                units.push_back((ndig == 2) ? sed_pkg::CH_X : sed_pkg::CH_U);
                repeat (ndig)
                begin
                    units.push_back(digit_unit($urandom_range(0, 15)));
                end
            end
            else if (pick < 90)
            begin
                ndig = ($urandom_range(0, 1) == 1) ? 4 : 2;
                units.push_back(sed_pkg::CH_BACKSLASH);
                units.push_back((ndig == 2) ? sed_pkg::CH_X : sed_pkg::CH_U);
                repeat ($urandom_range(0, ndig - 1))
                begin
                    units.push_back(digit_unit($urandom_range(0, 15)));
                end
                units.push_back(non_hex_unit());
            end
            else if (pick < 95)
            begin
                units.push_back(sed_pkg::CH_BACKSLASH);
                case ($urandom_range(0, 3))
                    0, 1: units.push_back(16'($urandom_range(0, 31)));
                    2: units.push_back(16'($urandom_range(127, 255)));
                    default: units.push_back(wide_unit());
                endcase
            end
            else
            begin
                units.push_back(sed_pkg::CH_BACKSLASH);
            end
        end
        // cut some strings short so that some escapes end unfinished
        if (units.size() > 1 && $urandom_range(0, 6) == 0)
        begin
            cut = $urandom_range(1, units.size() - 1);
            units = units[0:cut-1];
        end
        foreach (units[i])
        begin
            send_unit(units[i], (i == units.size() - 1));
            random_sent++;
        end
    endtask

    initial
    begin
        bit drained_mid;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        out_taken   = 1'b0;
        out_wait    = 0;
        in_burst    = 1'b0;
        out_burst   = 1'b0;
        cycle_count = 0;
        units_sent  = 0;
        random_sent = 0;
        drained_mid = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // plain extremes
        send_unit(16'h0000, 1'b1);
        send_unit(16'hFFFF, 1'b1);
        // two and four digit hex, mixed case
        send_unit(sed_pkg::CH_BACKSLASH, 1'b0);
        send_unit(sed_pkg::CH_X, 1'b0);
        send_unit(16'h0046, 1'b0);
        send_unit(16'h0066, 1'b1);
        send_unit(sed_pkg::CH_BACKSLASH, 1'b0);
        send_unit(sed_pkg::CH_U, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0030, 1'b0);
        send_unit(16'h0062, 1'b0);
        send_unit(16'h0039, 1'b1);
        // lone backslash at end, cut hex escape
        send_unit(sed_pkg::CH_BACKSLASH, 1'b1);
        send_unit(sed_pkg::CH_BACKSLASH, 1'b0);
        send_unit(sed_pkg::CH_X, 1'b0);
        send_unit(16'h0034, 1'b1);
        // unprintable escape, then units swallowed until the end
        send_unit(sed_pkg::CH_BACKSLASH, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0042, 1'b1);
        // bad hex digit on the last unit
        send_unit(sed_pkg::CH_BACKSLASH, 1'b0);
        send_unit(sed_pkg::CH_U, 1'b0);
        send_unit(16'h0047, 1'b1);
        // delete char is unprintable, tilde stands for itself
        send_unit(sed_pkg::CH_BACKSLASH, 1'b0);
        send_unit(16'h007F, 1'b1);
        send_unit(sed_pkg::CH_BACKSLASH, 1'b0);
        send_unit(sed_pkg::CH_PRINT_HI, 1'b1);

        wait_drained();

        while (random_sent < RANDOM_UNITS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                in_burst = !in_burst;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                out_burst = !out_burst;
            end
            if (!drained_mid && random_sent >= RANDOM_UNITS / 2)
            begin
                drained_mid = 1'b1;
                wait_drained();
            end
            send_random_string();
        end

        wait_drained();
        repeat (10) @(negedge clk);

        $display("sent %0d code units in %0d strings, %0d ended with an error status",
                 units_sent, strings_ended, error_ends);
        $display("checked %0d result words under random gaps and back pressure",
                 words_checked);
        if (mismatches == 0 && pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d words never arrived", mismatches, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/sed_pkg.sv
src/sed_parse.sv
src/sed_out_buf.sv
src/string_escape_decoder_unit.sv
src/sed_checker.sv
tb/sed_checker.sv
tb/string_escape_decoder_unit_test.sv
